// ===== rtl/bgr_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers for the grbg nearest-neighbor demosaic
// no dependencies
package bgr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int SIZE_W     = 11;
  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
  localparam int PAIR_W     = 2 * PIX_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;

  typedef struct packed {
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } blk_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] val,
                                                 input logic [SIZE_W-1:0] cap);
    logic [SIZE_W-1:0] v;
    v = {val[SIZE_W-1:1], 1'b0};
    if (v == '0) v = SIZE_W'(2);
    if (v > cap) v = {cap[SIZE_W-1:1], 1'b0};
    return v;
  endfunction

endpackage

// ===== rtl/bgr_in_if.sv =====
`timescale 1ns / 1ps
// raw sample request channel
// depends on bgr_pkg
interface bgr_in_if;
  import bgr_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

// ===== rtl/bgr_out_if.sv =====
`timescale 1ns / 1ps
// rgb pixel request channel
// depends on bgr_pkg
interface bgr_out_if;
  import bgr_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   red;
  logic [PIX_W-1:0]   green;
  logic [PIX_W-1:0]   blue;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic               last;
  modport source (output valid, output red, output green, output blue,
                  output pixel_x, output pixel_y, output last, input ready);
  modport sink (input valid, input red, input green, input blue,
                input pixel_x, input pixel_y, input last, output ready);
endinterface

// ===== rtl/bgr_cfg_if.sv =====
`timescale 1ns / 1ps
// configuration write channel
// depends on bgr_pkg
interface bgr_cfg_if;
  import bgr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bayer_grbg_to_rgb_nearest.sv =====
`timescale 1ns / 1ps
// channel  dir  payload                                   handshake
// in_ch    in   raw_sample[7:0]                           valid/ready
// out_ch   out  red, green, blue, pixel_x, pixel_y, last   valid/ready
// cfg_ch   in   index[0] (0 width, 1 height), data[10:0]  valid/ready, always ready
// one sample a cycle except blue: a blue block gives four pixels, one a cycle while
// out_ready is high, so odd rows run slower, bound by the single output register
// pair store is a 512x16 ram, written on even rows, read on blue samples
// reset clears counters and valid flags; store contents stay undefined
// a stalled output holds one blue block in the hold stage before intake stops
// top level: config registers, intake, pair store ram and output burst
// depends on bgr_pkg, bgr_*_if, bgr_front, bgr_ram, bgr_burst
module bayer_grbg_to_rgb_nearest
  import bgr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  bgr_in_if.sink    in_ch,
  bgr_out_if.source out_ch,
  bgr_cfg_if.sink   cfg_ch
);

  logic [SIZE_W-1:0]  frame_width_r, frame_height_r;
  logic [SIZE_W-1:0]  w_eff, h_eff;
  logic               ram_we, ram_re;
  logic [PAIR_AW-1:0] ram_waddr, ram_raddr;
  logic [PAIR_W-1:0]  ram_wdata, ram_rdata;
  logic               blk_valid, blk_take;
  blk_t               blk;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_ch.data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign w_eff = eff_size(frame_width_r, SIZE_W'(MAX_WIDTH));
  assign h_eff = eff_size(frame_height_r, SIZE_W'(MAX_HEIGHT));

  bgr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_sample (in_ch.raw_sample),
    .in_ready  (in_ch.ready),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .blk_valid (blk_valid),
    .blk       (blk),
    .blk_take  (blk_take)
  );

  bgr_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (PAIR_DEPTH)
  ) u_pair_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  bgr_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .blk_valid (blk_valid),
    .blk       (blk),
    .blk_take  (blk_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_red   (out_ch.red),
    .out_green (out_ch.green),
    .out_blue  (out_ch.blue),
    .out_x     (out_ch.pixel_x),
    .out_y     (out_ch.pixel_y),
    .out_last  (out_ch.last)
  );

`ifndef SYNTH
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |-> out_ch.pixel_x[0] && out_ch.pixel_y[0])
    else $error("last pixel not at lower right of block");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
    else $error("burst ended before its last pixel");

  a_stall_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> blk_valid && out_ch.valid)
    else $error("intake stalled without a held block");

  a_ram_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("pair store read and written by one sample");
`endif

endmodule

// ===== rtl/bgr_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module bgr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bgr_front.sv =====
`timescale 1ns / 1ps
// sample intake: raster counters, pair store access and blue hold stage
// depends on bgr_pkg; drives an external bgr_ram
module bgr_front
  import bgr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [PIX_W-1:0]   in_sample,
  output logic               in_ready,
  input  logic [SIZE_W-1:0]  w_eff,
  input  logic [SIZE_W-1:0]  h_eff,
  output logic               ram_we,
  output logic [PAIR_AW-1:0] ram_waddr,
  output logic [PAIR_W-1:0]  ram_wdata,
  output logic               ram_re,
  output logic [PAIR_AW-1:0] ram_raddr,
  input  logic [PAIR_W-1:0]  ram_rdata,
  output logic               blk_valid,
  output blk_t               blk,
  input  logic               blk_take
);

  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]   s1_blue_r;
  logic [COORD_W-1:0] s1_x_r, s1_y_r;
  logic [PIX_W-1:0]   green_r;
  logic               green_rd_r;
  logic [PIX_W-1:0]   green_old;
  logic               accept, is_blue, even_row;
  logic [SIZE_W-1:0]  col_p1, row_p1;

  assign in_ready = !s1_valid_r || blk_take;
  assign accept   = in_valid && in_ready;
  assign even_row = !row_r[0];
  assign is_blue  = row_r[0] && !col_r[0];

  // after a blue the row may wrap mid-line, then the green comes back from the store
  assign green_old = green_rd_r ? ram_rdata[PIX_W-1:0] : green_r;

  // pair store: green in low byte, red in high byte
  assign ram_we    = accept && even_row;
  assign ram_waddr = col_r[COORD_W-1:1];
  assign ram_wdata = col_r[0] ? {in_sample, green_old} : {{PIX_W{1'b0}}, in_sample};
  assign ram_re    = accept && is_blue;
  assign ram_raddr = col_r[COORD_W-1:1];

  always_comb begin
    col_p1  = {1'b0, col_r} + SIZE_W'(1);
    row_p1  = {1'b0, row_r};
    col_nxt = col_p1[COORD_W-1:0];
    if (col_p1 >= w_eff) begin
      col_nxt = '0;
      row_p1  = {1'b0, row_r} + SIZE_W'(1);
    end
    row_nxt = (row_p1 >= h_eff) ? '0 : row_p1[COORD_W-1:0];
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (blk_take) s1_valid_nxt = 1'b0;
    if (accept && is_blue) s1_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      green_rd_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept && is_blue) green_rd_r <= 1'b1;
      else if (accept && even_row && !col_r[0]) green_rd_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && even_row && !col_r[0]) green_r <= in_sample;
    if (accept && is_blue) begin
      s1_blue_r <= in_sample;
      s1_x_r    <= col_r;
      s1_y_r    <= row_r;
    end
  end

  assign blk_valid = s1_valid_r;
  assign blk.red   = ram_rdata[PAIR_W-1:PIX_W];
  assign blk.green = ram_rdata[PIX_W-1:0];
  assign blk.blue  = s1_blue_r;
  assign blk.x     = s1_x_r;
  assign blk.y     = s1_y_r;

endmodule

// ===== rtl/bgr_burst.sv =====
`timescale 1ns / 1ps
// output register that spreads one block color over its four pixels
// depends on bgr_pkg
module bgr_burst
  import bgr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               blk_valid,
  input  blk_t               blk,
  output logic               blk_take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_red,
  output logic [PIX_W-1:0]   out_green,
  output logic [PIX_W-1:0]   out_blue,
  output logic [COORD_W-1:0] out_x,
  output logic [COORD_W-1:0] out_y,
  output logic               out_last
);

  logic       valid_r;
  logic [1:0] cnt_r;
  blk_t       blk_r;
  logic       done;

  assign out_last = (cnt_r == 2'd3);
  assign done     = valid_r && out_ready && out_last;
  assign blk_take = blk_valid && (!valid_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (blk_take) begin
      valid_r <= 1'b1;
      cnt_r   <= '0;
    end else if (valid_r && out_ready) begin
      if (out_last) valid_r <= 1'b0;
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_take) blk_r <= blk;
  end

  // order: upper left, upper right, lower left, lower right
  assign out_valid = valid_r;
  assign out_red   = blk_r.red;
  assign out_green = blk_r.green;
  assign out_blue  = blk_r.blue;
  assign out_x     = {blk_r.x[COORD_W-1:1], cnt_r[0]};
  assign out_y     = {blk_r.y[COORD_W-1:1], cnt_r[1]};

endmodule
